@@ sv/gdrs_pkg.sv @@
// Package for the landing gear and door retract sequencer.
// Holds widths, command and register codes, shared types and the time saturation helper.
// No dependencies; every other file of the block imports it.
package gdrs_pkg;

   // Field and register widths.
   localparam int CMD_W      = 3;
   localparam int MS_W       = 16;
   localparam int POS_W      = 10;
   localparam int TIME_W     = 15;
   localparam int TYPE_W     = 2;
   localparam int TRAVEL_W   = 14;
   localparam int DELAY_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Signed width of the timeline points, wide enough for the unshifted door end.
   localparam int TL_W = 18;

   // Serial divider: quotient of t*512/travel never exceeds 512.
   localparam int QUO_W     = 10;
   localparam int DIV_STEPS = 10;
   localparam int DIV_CNT_W = 4;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DOWN       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UP         = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OPEN       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLOSE      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GEAR_START = 3'd5;
   localparam logic [CMD_W-1:0] CMD_GEAR_END   = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_TRAVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_TRAVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_DELAY  = 2'd3;

   // Door types; any other code drives the gear servo only.
   localparam logic [TYPE_W-1:0] TYPE_GEAR_ONLY = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_AVERAGED  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_SPLIT     = 2'd2;

   // Reset values.
   localparam logic [TRAVEL_W-1:0] RST_TRAVEL_MS = 14'd100;
   localparam logic [DELAY_W-1:0]  RST_DELAY_MS  = 15'd0;

   // Servo limits and the offset that centers the quotient.
   localparam logic signed [POS_W-1:0] POS_MIN    = -10'sd256;
   localparam logic signed [POS_W-1:0] POS_MAX    = 10'sd256;
   localparam logic [QUO_W-1:0]        QUO_OFFSET = 10'd256;

   localparam logic [TIME_W-1:0] TIME_MAX = 15'h7FFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETTLE1,
      ST_SETTLE2,
      ST_UPDATE,
      ST_GEAR_LOAD,
      ST_GEAR_DIV,
      ST_DOOR_LOAD,
      ST_DOOR_DIV,
      ST_APPLY,
      ST_FINISH
   } state_type;

   // Timeline points in milliseconds.
   typedef struct packed {
      logic signed [TL_W-1:0] gear_start;
      logic signed [TL_W-1:0] gear_end;
      logic signed [TL_W-1:0] door_start;
      logic signed [TL_W-1:0] door_end;
   } tline_type;

   // Request and status of the shared divider.
   typedef struct packed {
      logic                start;
      logic [TRAVEL_W-1:0] num;
      logic [TRAVEL_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

   // Clamp a timeline point into the range of the time registers.
   function automatic logic [TIME_W-1:0] sat_time(input logic signed [TL_W-1:0] t);
      logic signed [TL_W-1:0] lim;
      lim = $signed({{(TL_W-TIME_W){1'b0}}, TIME_MAX});
      if (t < 0) begin
         return '0;
      end else if (t > lim) begin
         return TIME_MAX;
      end
      return t[TIME_W-1:0];
   endfunction

endpackage

@@ sv/gdrs_req_if.sv @@
// Command channel of the gear and door sequencer: valid, ready and one command item.
// Depends on gdrs_pkg for the field widths.
interface gdrs_req_if;
   import gdrs_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [MS_W-1:0]   elapsed_ms;

   modport source (output valid, cmd, elapsed_ms, input ready);
   modport sink   (input valid, cmd, elapsed_ms, output ready);
endinterface

@@ sv/gdrs_rsp_if.sv @@
// Result channel of the gear and door sequencer: servo positions, time and timeline flags.
// Depends on gdrs_pkg for the field widths.
interface gdrs_rsp_if;
   import gdrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  gear_position;
   logic signed [POS_W-1:0]  doors_position;
   logic [TIME_W-1:0]        timeline_now;
   logic                     fully_up;
   logic                     fully_down;
   logic                     doors_at_start;
   logic                     doors_at_end;
   logic                     gear_at_start;
   logic                     gear_at_end;

   modport source (output valid, gear_position, doors_position, timeline_now, fully_up,
                   fully_down, doors_at_start, doors_at_end, gear_at_start, gear_at_end,
                   input ready);
   modport sink   (input valid, gear_position, doors_position, timeline_now, fully_up,
                   fully_down, doors_at_start, doors_at_end, gear_at_start, gear_at_end,
                   output ready);
endinterface

@@ sv/gear_door_retract_sequencer_unit.sv @@
// Landing gear and door retract sequencer. Each command item yields exactly one result item
// holding both servo positions, the current timeline point and six timeline flags. A command
// other than tick, or a tick whose target is already reached, goes from the settling states
// through the update state straight to the finish state; a moving tick also has the shared
// serial divider run two 10-step passes, one for the gear segment and one for the door
// segment, each started from its load state. A segment with zero travel time skips its pass.
// The block takes one item at a time; a finished result waits in an output register, so the
// next item may be accepted before it is taken, and a result still waiting there holds the
// next one back. The timeline follows register writes through the registers of gdrs_tline.
// Depends on gdrs_pkg, gdrs_req_if, gdrs_rsp_if, gdrs_div and gdrs_tline.
module gear_door_retract_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   gdrs_req_if.sink                          req_if,
   gdrs_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [gdrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gdrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gdrs_pkg::*;

   // Configuration registers.
   logic [TYPE_W-1:0]   door_type_ff;
   logic [TRAVEL_W-1:0] door_travel_ff;
   logic [TRAVEL_W-1:0] gear_travel_ff;
   logic [DELAY_W-1:0]  door_delay_ff;

   // Sequencer and datapath state.
   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [MS_W-1:0]         elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]       cur_ff, cur_in;
   logic [TIME_W-1:0]       tgt_ff, tgt_in;
   logic signed [POS_W-1:0] gear_servo_ff, gear_servo_in;
   logic signed [POS_W-1:0] door_servo_ff, door_servo_in;
   logic signed [POS_W-1:0] gp_ff, gp_in;
   logic signed [POS_W-1:0] dp_ff, dp_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] out_gear_ff, out_gear_in;
   logic signed [POS_W-1:0] out_door_ff, out_door_in;
   logic [TIME_W-1:0]       out_now_ff, out_now_in;
   logic [5:0]              out_flags_ff, out_flags_in;

   tline_type   tline;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic signed [TL_W-1:0]  seg_start, seg_diff, cur_s, up_pt, down_pt;
   logic [TRAVEL_W-1:0]     seg_travel, seg_t;
   logic signed [POS_W-1:0] seg_direct, quo_pos;
   logic [TIME_W+1:0]       sum_up;
   logic signed [TL_W-1:0]  sum_down;
   logic signed [POS_W:0]   pos_sum;
   logic signed [POS_W:0]   pos_avg;
   logic                    out_free;

   gdrs_tline u_tline (
      .clock       (clock),
      .gear_travel (gear_travel_ff),
      .door_travel (door_travel_ff),
      .door_delay  (door_delay_ff),
      .tline       (tline)
   );

   gdrs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         door_type_ff   <= TYPE_GEAR_ONLY;
         door_travel_ff <= RST_TRAVEL_MS;
         gear_travel_ff <= RST_TRAVEL_MS;
         door_delay_ff  <= RST_DELAY_MS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DOOR_TYPE:   door_type_ff   <= csr_wdata[TYPE_W-1:0];
            CSR_DOOR_TRAVEL: door_travel_ff <= csr_wdata[TRAVEL_W-1:0];
            CSR_GEAR_TRAVEL: gear_travel_ff <= csr_wdata[TRAVEL_W-1:0];
            CSR_DOOR_DELAY:  door_delay_ff  <= csr_wdata[DELAY_W-1:0];
         endcase
      end
   end

   // Segment clamp: time into the segment limited to 0..travel, and the zero-travel answer.
   always_comb begin
      cur_s = $signed({{(TL_W-TIME_W){1'b0}}, cur_ff});
      if (state_ff == ST_GEAR_LOAD) begin
         seg_start  = tline.gear_start;
         seg_travel = gear_travel_ff;
      end else begin
         seg_start  = tline.door_start;
         seg_travel = door_travel_ff;
      end
      seg_diff   = cur_s - seg_start;
      seg_direct = (seg_diff >= 0) ? POS_MAX : POS_MIN;
      if (seg_diff < 0) begin
         seg_t = '0;
      end else if (seg_diff > $signed({{(TL_W-TRAVEL_W){1'b0}}, seg_travel})) begin
         seg_t = seg_travel;
      end else begin
         seg_t = seg_diff[TRAVEL_W-1:0];
      end
      quo_pos = $signed(div_rsp.quo - QUO_OFFSET);
   end

   // Time step, averaging and the end points of the timeline.
   always_comb begin
      sum_up   = {2'b00, cur_ff} + {1'b0, elapsed_ff};
      sum_down = cur_s - $signed({{(TL_W-MS_W){1'b0}}, elapsed_ff});
      pos_sum  = $signed({gp_ff[POS_W-1], gp_ff}) + $signed({dp_ff[POS_W-1], dp_ff});
      pos_avg  = (pos_sum + $signed({{POS_W{1'b0}}, pos_sum[POS_W]})) >>> 1;
      up_pt    = (tline.door_end > tline.gear_end) ? tline.door_end : tline.gear_end;
      down_pt  = (tline.door_start < tline.gear_start) ? tline.door_start : tline.gear_start;
      out_free = !rsp_valid_ff || rsp_if.ready;
   end

   // Sequencer: next state and next values of the datapath.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      elapsed_in    = elapsed_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      gear_servo_in = gear_servo_ff;
      door_servo_in = door_servo_ff;
      gp_in         = gp_ff;
      dp_in         = dp_ff;
      div_req.start = 1'b0;
      div_req.num   = seg_t;
      div_req.den   = seg_travel;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      out_gear_in   = out_gear_ff;
      out_door_in   = out_door_ff;
      out_now_in    = out_now_ff;
      out_flags_in  = out_flags_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in     = req_if.cmd;
               elapsed_in = req_if.elapsed_ms;
               state_in   = ST_SETTLE1;
            end
         end
         // The settling states let the timeline catch up with a register written just before.
         ST_SETTLE1: state_in = ST_SETTLE2;
         ST_SETTLE2: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = ST_FINISH;
            unique case (cmd_ff)
               CMD_TICK: begin
                  if (tgt_ff != cur_ff) begin
                     state_in = ST_GEAR_LOAD;
                     if (tgt_ff > cur_ff) begin
                        cur_in = (sum_up > {2'b00, tgt_ff}) ? tgt_ff : sum_up[TIME_W-1:0];
                     end else begin
                        cur_in = (sum_down < 0) ? '0 : sum_down[TIME_W-1:0];
                     end
                  end
               end
               CMD_DOWN:       tgt_in = '0;
               CMD_UP:         tgt_in = sat_time(up_pt);
               CMD_OPEN:       tgt_in = sat_time(down_pt);
               CMD_CLOSE:      tgt_in = sat_time(tline.door_end);
               CMD_GEAR_START: tgt_in = sat_time(tline.gear_start);
               CMD_GEAR_END:   tgt_in = sat_time(tline.gear_end);
               default: ;
            endcase
         end
         ST_GEAR_LOAD: begin
            if (gear_travel_ff == '0) begin
               gp_in    = seg_direct;
               state_in = ST_DOOR_LOAD;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_GEAR_DIV;
            end
         end
         ST_GEAR_DIV: begin
            if (div_rsp.done) begin
               gp_in    = quo_pos;
               state_in = ST_DOOR_LOAD;
            end
         end
         ST_DOOR_LOAD: begin
            if (door_travel_ff == '0) begin
               dp_in    = seg_direct;
               state_in = ST_APPLY;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DOOR_DIV;
            end
         end
         ST_DOOR_DIV: begin
            if (div_rsp.done) begin
               dp_in    = quo_pos;
               state_in = ST_APPLY;
            end
         end
         // Map the segment positions onto the servos of the chosen door type.
         ST_APPLY: begin
            state_in = ST_FINISH;
            if (door_type_ff == TYPE_AVERAGED) begin
               gear_servo_in = pos_avg[POS_W-1:0];
               door_servo_in = pos_avg[POS_W-1:0];
            end else if (door_type_ff == TYPE_SPLIT) begin
               gear_servo_in = gp_ff;
               door_servo_in = dp_ff;
            end else begin
               gear_servo_in = gp_ff;
            end
         end
         // Hand the item to the output register once it is free.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_gear_in  = gear_servo_ff;
               out_door_in  = door_servo_ff;
               out_now_in   = cur_ff;
               out_flags_in = {cur_s >= up_pt,
                               cur_s <= down_pt,
                               cur_s <= tline.door_start,
                               cur_s >= tline.door_end,
                               cur_s <= tline.gear_start,
                               cur_s >= tline.gear_end};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_ff        <= '0;
         tgt_ff        <= '0;
         gear_servo_ff <= POS_MIN;
         door_servo_ff <= POS_MIN;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_ff        <= cur_in;
         tgt_ff        <= tgt_in;
         gear_servo_ff <= gear_servo_in;
         door_servo_ff <= door_servo_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      elapsed_ff   <= elapsed_in;
      gp_ff        <= gp_in;
      dp_ff        <= dp_in;
      out_gear_ff  <= out_gear_in;
      out_door_ff  <= out_door_in;
      out_now_ff   <= out_now_in;
      out_flags_ff <= out_flags_in;
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.gear_position  = out_gear_ff;
   assign rsp_if.doors_position = out_door_ff;
   assign rsp_if.timeline_now   = out_now_ff;
   assign rsp_if.fully_up       = out_flags_ff[5];
   assign rsp_if.fully_down     = out_flags_ff[4];
   assign rsp_if.doors_at_start = out_flags_ff[3];
   assign rsp_if.doors_at_end   = out_flags_ff[2];
   assign rsp_if.gear_at_start  = out_flags_ff[1];
   assign rsp_if.gear_at_end    = out_flags_ff[0];

   // An accepted item always starts with the timeline settling cycles.
   a_accept_settle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_SETTLE1))
      else $error("accepted item did not enter the settling cycles");

   // The divider is started only from a segment load state.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_GEAR_LOAD || state_ff == ST_DOOR_LOAD))
      else $error("divider started outside a segment load");

   // A divider result arrives only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_GEAR_DIV || state_ff == ST_DOOR_DIV))
      else $error("divider result arrived with nobody waiting");

   // Servo positions stay within full travel.
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      (gear_servo_ff >= POS_MIN && gear_servo_ff <= POS_MAX &&
       door_servo_ff >= POS_MIN && door_servo_ff <= POS_MAX))
      else $error("servo position out of range");

endmodule

@@ sv/gdrs_div.sv @@
// Serial restoring divider computing (num*512)/den, one quotient bit per cycle.
// Depends on gdrs_pkg for widths and the request and status structs.
module gdrs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gdrs_pkg::div_req_type req,
   output gdrs_pkg::div_rsp_type rsp
);
   import gdrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 lsb_ff, lsb_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TRAVEL_W-1:0]  rem_ff, rem_in;
   logic [TRAVEL_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [TRAVEL_W:0]    trial;
   logic                 fits;

   // One step: shift in the next dividend bit and try to subtract the divisor.
   // The dividend is num followed by nine zeros, so only the first step brings in num[0].
   always_comb begin
      trial   = {rem_ff, lsb_ff};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      lsb_in  = lsb_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         lsb_in  = req.num[0];
         cnt_in  = '0;
         rem_in  = {1'b0, req.num[TRAVEL_W-1:1]};
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         lsb_in = 1'b0;
         rem_in = fits ? TRAVEL_W'(trial - {1'b0, den_ff}) : trial[TRAVEL_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lsb_ff <= lsb_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ sv/gdrs_tline.sv @@
// Two-stage derivation of the gear and door timeline from the travel and delay registers.
// Depends on gdrs_pkg for widths and the timeline struct.
module gdrs_tline (
   input  logic                                  clock,
   input  logic [gdrs_pkg::TRAVEL_W-1:0]         gear_travel,
   input  logic [gdrs_pkg::TRAVEL_W-1:0]         door_travel,
   input  logic [gdrs_pkg::DELAY_W-1:0]          door_delay,
   output gdrs_pkg::tline_type                   tline
);
   import gdrs_pkg::*;

   logic signed [TL_W-1:0] g_s, d_s, dly_s, ds_raw, de_raw;
   logic signed [TL_W-1:0] ds1_in, de1_in, ds1_ff, de1_ff, g1_ff;
   tline_type              tline_in, tline_ff;

   // First stage: door after gear plus delay; pull the door start back if it ends early.
   always_comb begin
      g_s    = $signed({{(TL_W-TRAVEL_W){1'b0}}, gear_travel});
      d_s    = $signed({{(TL_W-TRAVEL_W){1'b0}}, door_travel});
      dly_s  = $signed({{(TL_W-DELAY_W){door_delay[DELAY_W-1]}}, door_delay});
      ds_raw = g_s + dly_s;
      de_raw = ds_raw + d_s;
      if (de_raw < g_s) begin
         ds1_in = g_s - d_s;
         de1_in = g_s;
      end else begin
         ds1_in = ds_raw;
         de1_in = de_raw;
      end
   end

   // Second stage: shift the whole timeline up when the door start is negative.
   always_comb begin
      if (ds1_ff < 0) begin
         tline_in.gear_start = -ds1_ff;
         tline_in.gear_end   = g1_ff - ds1_ff;
         tline_in.door_start = '0;
         tline_in.door_end   = de1_ff - ds1_ff;
      end else begin
         tline_in.gear_start = '0;
         tline_in.gear_end   = g1_ff;
         tline_in.door_start = ds1_ff;
         tline_in.door_end   = de1_ff;
      end
   end

   // Both stages follow the registers every cycle.
   always_ff @(posedge clock) begin
      ds1_ff   <= ds1_in;
      de1_ff   <= de1_in;
      g1_ff    <= g_s;
      tline_ff <= tline_in;
   end

   assign tline = tline_ff;

endmodule

@@ tb/gear_door_retract_sequencer_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gear_door_retract_sequencer_unit: command and tick items go in,
// every result item is compared with a timeline predictor that follows each register write.
// Depends on gdrs_pkg, gdrs_req_if, gdrs_rsp_if and the sequencer RTL.
module gear_door_retract_sequencer_unit_test;
   import gdrs_pkg::*;

   localparam int RESET_CYCLES      = 5;
   localparam int STALL_LIMIT       = 4000;
   localparam int HOLD_OFF_CYCLES   = 400;
   localparam int SETTLE_CYCLES     = 8;
   localparam int DRAIN_CYCLES      = 40;
   localparam int ITEMS_PER_SETTING = 140;
   localparam int NUM_SETTINGS      = 9;
   localparam int PRESSURE_SETTING  = 4;
   localparam int POS_FULL          = 256;
   localparam int POS_SCALE         = 512;
   localparam int MS_FULL           = 65535;

   // Codes the block treats as don't-care.
   localparam logic [CMD_W-1:0]  CMD_UNUSED  = 3'd7;
   localparam logic [TYPE_W-1:0] TYPE_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [MS_W-1:0]  elapsed_ms;
   } cmd_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] gear_position;
      logic signed [POS_W-1:0] doors_position;
      logic [TIME_W-1:0]       timeline_now;
      logic                    fully_up;
      logic                    fully_down;
      logic                    doors_at_start;
      logic                    doors_at_end;
      logic                    gear_at_start;
      logic                    gear_at_end;
   } servo_status_type;

   typedef struct {
      int gear_start;
      int gear_end;
      int door_start;
      int door_end;
   } timeline_pts_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gdrs_req_if req_if();
   gdrs_rsp_if rsp_if();

   gear_door_retract_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and of the sequencer state.
   logic [TYPE_W-1:0]          door_type_q;
   logic [TRAVEL_W-1:0]        door_travel_q;
   logic [TRAVEL_W-1:0]        gear_travel_q;
   logic signed [DELAY_W-1:0]  door_delay_q;
   int now_ms;
   int target_ms;
   int gear_servo_pos;
   int door_servo_pos;

   cmd_item_type     pending_cmds[$];
   servo_status_type expected_status[$];

   int send_idle_pct;
   int recv_stall_pct;
   int setting_no;
   int hold_left;
   bit hold_done;
   int errors;
   int items_sent;
   int results_seen;
   int idle_cycles;

   always #2 clock = ~clock;

   // Timeline points as the registers define them, door start pulled back and shifted up.
   function automatic timeline_pts_type derive_timeline();
      timeline_pts_type tl;
      int shift;
      tl.gear_start = 0;
      tl.gear_end   = int'(gear_travel_q);
      tl.door_start = tl.gear_end + int'(door_delay_q);
      tl.door_end   = tl.door_start + int'(door_travel_q);
      if (tl.door_end < tl.gear_end) begin
         tl.door_end   = tl.gear_end;
         tl.door_start = tl.door_end - int'(door_travel_q);
      end
      if (tl.door_start < 0) begin
         shift = -tl.door_start;
         tl.gear_start += shift;
         tl.gear_end   += shift;
         tl.door_start += shift;
         tl.door_end   += shift;
      end
      return tl;
   endfunction

   function automatic int clamp_target(int t);
      if (t > int'(TIME_MAX)) begin
         return int'(TIME_MAX);
      end else if (t < 0) begin
         return 0;
      end
      return t;
   endfunction

   // Servo position of one segment; a zero travel time snaps to either end.
   function automatic int segment_position(int start, int travel);
      int t;
      t = now_ms - start;
      if (travel == 0) begin
         return (t >= 0) ? POS_FULL : -POS_FULL;
      end
      if (t < 0) begin
         t = 0;
      end else if (t > travel) begin
         t = travel;
      end
      return (t * POS_SCALE) / travel - POS_FULL;
   endfunction

   // Apply one command item to the predicted state and return the status it reports.
   function automatic servo_status_type advance_sequencer(cmd_item_type it);
      timeline_pts_type tl;
      servo_status_type st;
      int last_end;
      int first_start;
      int gp;
      int dp;
      tl          = derive_timeline();
      last_end    = (tl.door_end > tl.gear_end) ? tl.door_end : tl.gear_end;
      first_start = (tl.door_start < tl.gear_start) ? tl.door_start : tl.gear_start;
      case (it.cmd)
         CMD_TICK: begin
            if (target_ms != now_ms) begin
               // Upward moves stop at the target, downward ones only at zero.
               if (target_ms > now_ms) begin
                  now_ms += int'(it.elapsed_ms);
                  if (now_ms > target_ms) now_ms = target_ms;
               end else begin
                  now_ms -= int'(it.elapsed_ms);
                  if (now_ms < 0) now_ms = 0;
               end
               gp = segment_position(tl.gear_start, int'(gear_travel_q));
               dp = segment_position(tl.door_start, int'(door_travel_q));
               if (door_type_q == TYPE_AVERAGED) begin
                  gear_servo_pos = (gp + dp) / 2;
                  door_servo_pos = gear_servo_pos;
               end else if (door_type_q == TYPE_SPLIT) begin
                  gear_servo_pos = gp;
                  door_servo_pos = dp;
               end else begin
                  gear_servo_pos = gp;
               end
            end
         end
         CMD_DOWN:       target_ms = clamp_target(0);
         CMD_UP:         target_ms = clamp_target(last_end);
         CMD_OPEN:       target_ms = clamp_target(first_start);
         CMD_CLOSE:      target_ms = clamp_target(tl.door_end);
         CMD_GEAR_START: target_ms = clamp_target(tl.gear_start);
         CMD_GEAR_END:   target_ms = clamp_target(tl.gear_end);
         default: ;
      endcase
      st.gear_position  = gear_servo_pos[POS_W-1:0];
      st.doors_position = door_servo_pos[POS_W-1:0];
      st.timeline_now   = now_ms[TIME_W-1:0];
      st.fully_up       = (now_ms >= last_end);
      st.fully_down     = (now_ms <= first_start);
      st.doors_at_start = (now_ms <= tl.door_start);
      st.doors_at_end   = (now_ms >= tl.door_end);
      st.gear_at_start  = (now_ms <= tl.gear_start);
      st.gear_at_end    = (now_ms >= tl.gear_end);
      return st;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         errors++;
      end
   endtask

   task automatic push_cmd(logic [CMD_W-1:0] cmd, int ms);
      cmd_item_type it;
      it.cmd        = cmd;
      it.elapsed_ms = ms[MS_W-1:0];
      pending_cmds.push_back(it);
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_DOOR_TYPE:   door_type_q   = value[TYPE_W-1:0];
         CSR_DOOR_TRAVEL: door_travel_q = value[TRAVEL_W-1:0];
         CSR_GEAR_TRAVEL: gear_travel_q = value[TRAVEL_W-1:0];
         CSR_DOOR_DELAY:  door_delay_q  = value[DELAY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(int door_type, int door_ms, int gear_ms, int delay_ms);
      write_register(CSR_DOOR_TYPE, door_type);
      write_register(CSR_DOOR_TRAVEL, door_ms);
      write_register(CSR_GEAR_TRAVEL, gear_ms);
      write_register(CSR_DOOR_DELAY, delay_ms);
      @(posedge clock);
      csr_we <= 1'b0;
      // The timeline follows a write through the registers of gdrs_tline.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_if.valid || expected_status.size() != 0);
   endtask

   // Mostly steps on the scale of the timeline, with some zero and full-range steps.
   function automatic int pick_elapsed(int span);
      int r;
      r = $urandom_range(99);
      if (r < 8) begin
         return 0;
      end else if (r < 16) begin
         return $urandom_range(0, MS_FULL);
      end
      return $urandom_range(1, span / 5 + 1);
   endfunction

   // Mostly a command followed by a run of ticks; the rest is loose ticks and noise.
   task automatic queue_random_traffic(int count);
      timeline_pts_type tl;
      int span;
      int queued;
      int sel;
      int run;
      tl     = derive_timeline();
      span   = (tl.door_end > tl.gear_end) ? tl.door_end : tl.gear_end;
      queued = 0;
      while (queued < count) begin
         sel = $urandom_range(99);
         if (sel < 80) begin
            push_cmd(CMD_W'($urandom_range(CMD_DOWN, CMD_UNUSED)), $urandom_range(0, MS_FULL));
            run = $urandom_range(1, 8);
            queued += run + 1;
            repeat (run) push_cmd(CMD_TICK, pick_elapsed(span));
         end else if (sel < 92) begin
            push_cmd(CMD_TICK, $urandom_range(0, MS_FULL));
            queued++;
         end else begin
            push_cmd(CMD_W'($urandom_range(CMD_TICK, CMD_UNUSED)), $urandom_range(0, MS_FULL));
            queued++;
         end
      end
   endtask

   // Directed walk over the reset timeline: gear 0..100, doors 100..200.
   task automatic queue_directed();
      push_cmd(CMD_TICK, 0);              // target already reached, positions stay
      push_cmd(CMD_UP, MS_FULL);
      push_cmd(CMD_TICK, 0);              // moving, but by nothing
      push_cmd(CMD_TICK, 37);
      push_cmd(CMD_TICK, MS_FULL);        // stops at the target
      push_cmd(CMD_GEAR_END, 0);
      push_cmd(CMD_TICK, 150);            // moving down passes below the target
      push_cmd(CMD_TICK, 20);             // and a later tick climbs back up
      push_cmd(CMD_OPEN, 0);
      push_cmd(CMD_TICK, MS_FULL);        // stops at zero
      push_cmd(CMD_CLOSE, 0);
      push_cmd(CMD_TICK, 120);
      push_cmd(CMD_GEAR_START, 0);
      push_cmd(CMD_TICK, 30);
      push_cmd(CMD_DOWN, 0);
      push_cmd(CMD_UNUSED, MS_FULL);      // ignored command
      push_cmd(CMD_TICK, 1);
      push_cmd(CMD_TICK, MS_FULL);
      push_cmd(CMD_TICK, 5);
      push_cmd(CMD_GEAR_END, 0);
      push_cmd(CMD_TICK, 100);
   endtask

   // Command driver: offers queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      cmd_item_type taken;
      cmd_item_type next_item;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.cmd        <= CMD_TICK;
         req_if.elapsed_ms <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.cmd        = req_if.cmd;
            taken.elapsed_ms = req_if.elapsed_ms;
            expected_status.push_back(advance_sequencer(taken));
            items_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_cmds.pop_front();
               req_if.valid      <= 1'b1;
               req_if.cmd        <= next_item.cmd;
               req_if.elapsed_ms <= next_item.elapsed_ms;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted result and drives ready, with one long hold-off.
   always @(posedge clock) begin
      servo_status_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               $error("result item arrived with no command item outstanding");
               errors++;
            end else begin
               want = expected_status.pop_front();
               check_field("gear_position", int'($signed(want.gear_position)),
                           int'($signed(rsp_if.gear_position)));
               check_field("doors_position", int'($signed(want.doors_position)),
                           int'($signed(rsp_if.doors_position)));
               check_field("timeline_now", want.timeline_now, rsp_if.timeline_now);
               check_field("fully_up", want.fully_up, rsp_if.fully_up);
               check_field("fully_down", want.fully_down, rsp_if.fully_down);
               check_field("doors_at_start", want.doors_at_start, rsp_if.doors_at_start);
               check_field("doors_at_end", want.doors_at_end, rsp_if.doors_at_end);
               check_field("gear_at_start", want.gear_at_start, rsp_if.gear_at_start);
               check_field("gear_at_end", want.gear_at_end, rsp_if.gear_at_end);
            end
         end
         if (setting_no == PRESSURE_SETTING && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("No item moved for %0d cycles, giving up.", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      door_type_q       = TYPE_GEAR_ONLY;
      door_travel_q     = RST_TRAVEL_MS;
      gear_travel_q     = RST_TRAVEL_MS;
      door_delay_q      = RST_DELAY_MS;
      now_ms            = 0;
      target_ms         = 0;
      gear_servo_pos    = -POS_FULL;
      door_servo_pos    = -POS_FULL;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      setting_no        = -1;
      hold_left         = 0;
      hold_done         = 1'b0;
      errors            = 0;
      items_sent        = 0;
      results_seen      = 0;
      idle_cycles       = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      wait_for_drain();

      // Register settings: reset values, extremes, zero travel, saturating targets, random.
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         setting_no = s;
         case (s)
            0: apply_setting(TYPE_GEAR_ONLY, 100, 100, 0);
            1: apply_setting(TYPE_SPLIT, 1, 1, -16384);
            2: apply_setting(TYPE_AVERAGED, 16383, 16383, 16383);
            3: apply_setting(TYPE_UNUSED, 0, 0, 0);
            4: apply_setting(TYPE_SPLIT, 250, 400, -600);
            5: apply_setting(TYPE_AVERAGED, 10000, 1, -10000);
            6: apply_setting(TYPE_GEAR_ONLY, 0, 10000, 10000);
            default: apply_setting($urandom_range(0, 3), $urandom_range(0, 16383),
                                   $urandom_range(0, 16383), $urandom_range(0, 32767) - 16384);
         endcase
         case (s % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         queue_random_traffic(ITEMS_PER_SETTING);
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_status.size() != 0) begin
         $error("%0d expected result items never arrived", expected_status.size());
         errors++;
      end

      $display("Sent %0d command items and checked %0d results over %0d register settings,",
               items_sent, results_seen, NUM_SETTINGS + 1);
      $display("with idle and stall mixes and one long result hold-off; %0d errors.", errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/gdrs_pkg.sv
sv/gdrs_req_if.sv
sv/gdrs_rsp_if.sv
sv/gdrs_div.sv
sv/gdrs_tline.sv
sv/gear_door_retract_sequencer_unit.sv
tb/gear_door_retract_sequencer_unit_test.sv
